/* rtl/core/c3ic_pkg.sv */
`default_nettype none

package c3ic_pkg;

  localparam int PIX_W     = 8;
  localparam int GEO_W     = 13;
  localparam int GEO_MAX   = 8191;
  localparam int ROW_W     = 12;
  localparam int STRIDE_W  = 3;
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_IMAGE_ROWS = 4096;
  localparam int PIX_MAX        = 255;

  // Arithmetic widths of the weighted sum
  localparam int PROD_W = 17;
  localparam int RSUM_W = 19;
  localparam int SUM_W  = 21;

  // Queue between the window front and the arithmetic back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SAMPLES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_MID   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_BOT   = 3'd5;

  // Reset values: kernel -1 -1 -1 / -1 8 -1 / -1 -1 -1
  localparam logic [GEO_W-1:0]    RST_ROW_SAMPLES    = 13'd4096;
  localparam logic [GEO_W-1:0]    RST_IMAGE_ROWS     = 13'd4096;
  localparam logic [STRIDE_W-1:0] RST_CHANNEL_STRIDE = 3'd1;
  localparam logic [COEF_W-1:0]   RST_COEF_ROW_TOP   = 24'hFFFFFF;
  localparam logic [COEF_W-1:0]   RST_COEF_ROW_MID   = 24'hFF08FF;
  localparam logic [COEF_W-1:0]   RST_COEF_ROW_BOT   = 24'hFFFFFF;

  // Effective frame geometry after range limiting
  typedef struct packed {
    logic [GEO_W-1:0]    w;
    logic [GEO_W-1:0]    h;
    logic [STRIDE_W-1:0] s;
  } geo_t;

  // Kernel rows: index 0 top, 2 bottom; left weight in the low byte
  typedef struct packed {
    logic [2:0][COEF_W-1:0] row;
  } coef_t;

  // Nine masked taps of one result: tap[row][column], column 0 is left
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] tap;
    logic                       last;
  } taps_t;

endpackage

`default_nettype wire

/* rtl/core/conv3x3_interleaved_clamp.sv */
// 3x3 convolution of an 8-bit raster stream with interleaved channels, one sample per
// transaction in raster order. Horizontal taps lie channel_stride samples apart so each
// channel is filtered on its own; vertical taps lie one row apart; taps outside the image
// count as zero, and the weighted sum is clamped to 0..255. Result m of a frame is produced
// by the transaction that carries stream position m + row_samples + channel_stride, so after
// the last sample of a frame send row_samples + channel_stride drain transactions
// (in_command = 1) to flush it; out_frame_end marks the last result. A drain sent before the
// last sample, and a sample sent after it, is dropped without a result. Sustained rate is one
// transaction per clock on both sides; a result passes from the window stage through the queue
// and the product and row-sum registers into the output register, and the input stalls only
// when the four-entry queue in front of the multiplier pipeline, counting a result still in
// the window stage, is full because the output is back-pressured. Both line stores take one
// read and one write per clock; their unwritten entries after reset read as
// zero through a written-prefix count, so no clearing pass is needed. Weights are written
// as three signed bytes per kernel row, left tap in the low byte. Write registers only while
// the block is idle.
`default_nettype none

module conv3x3_interleaved_clamp #(
  parameter int MAX_ROW_SAMPLES = 4096,
  parameter int MAX_CHANNELS    = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_command,
  input  wire logic [c3ic_pkg::PIX_W-1:0]     in_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [c3ic_pkg::PIX_W-1:0]          out_sample,
  output logic                                out_frame_end,
  input  wire logic                           cfg_we,
  input  wire logic [c3ic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [c3ic_pkg::COEF_W-1:0]    cfg_wdata
);

  localparam int W_LIMIT = (MAX_ROW_SAMPLES > c3ic_pkg::GEO_MAX) ?
                           c3ic_pkg::GEO_MAX : MAX_ROW_SAMPLES;

  logic [c3ic_pkg::GEO_W-1:0]    row_samples_r, image_rows_r;
  logic [c3ic_pkg::STRIDE_W-1:0] channel_stride_r;
  logic [c3ic_pkg::COEF_W-1:0]   coef_top_r, coef_mid_r, coef_bot_r;

  c3ic_pkg::geo_t  geo;
  c3ic_pkg::coef_t coef;
  c3ic_pkg::taps_t q_wr_data, q_rd_data;
  logic                          q_push, q_pop, q_valid;
  logic [c3ic_pkg::Q_CNT_W-1:0]  q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_samples_r    <= c3ic_pkg::RST_ROW_SAMPLES;
      image_rows_r     <= c3ic_pkg::RST_IMAGE_ROWS;
      channel_stride_r <= c3ic_pkg::RST_CHANNEL_STRIDE;
      coef_top_r       <= c3ic_pkg::RST_COEF_ROW_TOP;
      coef_mid_r       <= c3ic_pkg::RST_COEF_ROW_MID;
      coef_bot_r       <= c3ic_pkg::RST_COEF_ROW_BOT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c3ic_pkg::REG_ROW_SAMPLES:    row_samples_r    <= cfg_wdata[c3ic_pkg::GEO_W-1:0];
        c3ic_pkg::REG_IMAGE_ROWS:     image_rows_r     <= cfg_wdata[c3ic_pkg::GEO_W-1:0];
        c3ic_pkg::REG_CHANNEL_STRIDE: channel_stride_r <= cfg_wdata[c3ic_pkg::STRIDE_W-1:0];
        c3ic_pkg::REG_COEF_ROW_TOP:   coef_top_r       <= cfg_wdata;
        c3ic_pkg::REG_COEF_ROW_MID:   coef_mid_r       <= cfg_wdata;
        c3ic_pkg::REG_COEF_ROW_BOT:   coef_bot_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Limit geometry to what the stores and window hold; zero acts as one
  always_comb begin
    priority if (row_samples_r == '0) begin
      geo.w = c3ic_pkg::GEO_W'(1);
    end else if (row_samples_r > c3ic_pkg::GEO_W'(W_LIMIT)) begin
      geo.w = c3ic_pkg::GEO_W'(W_LIMIT);
    end else begin
      geo.w = row_samples_r;
    end
    priority if (image_rows_r == '0) begin
      geo.h = c3ic_pkg::GEO_W'(1);
    end else if (image_rows_r > c3ic_pkg::GEO_W'(c3ic_pkg::MAX_IMAGE_ROWS)) begin
      geo.h = c3ic_pkg::GEO_W'(c3ic_pkg::MAX_IMAGE_ROWS);
    end else begin
      geo.h = image_rows_r;
    end
    priority if (channel_stride_r == '0) begin
      geo.s = c3ic_pkg::STRIDE_W'(1);
    end else if (channel_stride_r > c3ic_pkg::STRIDE_W'(MAX_CHANNELS)) begin
      geo.s = c3ic_pkg::STRIDE_W'(MAX_CHANNELS);
    end else begin
      geo.s = channel_stride_r;
    end
  end

  assign coef.row[0] = coef_top_r;
  assign coef.row[1] = coef_mid_r;
  assign coef.row[2] = coef_bot_r;

  c3ic_front #(
    .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES),
    .MAX_CHANNELS    (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_sample  (in_sample),
    .geo        (geo),
    .q_level    (q_level),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  c3ic_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (q_wr_data),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .not_empty (q_valid),
    .level     (q_level)
  );

  c3ic_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .coef          (coef),
    .q_valid       (q_valid),
    .q_data        (q_rd_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_frame_end (out_frame_end)
  );

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level != c3ic_pkg::Q_CNT_W'(c3ic_pkg::Q_DEPTH)) || q_pop)
    else $error("queue overflow");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_level != '0)
    else $error("queue underflow");

  // Accepting input always leaves room for the transaction in the window stage
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> q_level < c3ic_pkg::Q_CNT_W'(c3ic_pkg::Q_DEPTH))
    else $error("input ready with full queue");

endmodule

`default_nettype wire

/* rtl/core/c3ic_front.sv */
`default_nettype none

module c3ic_front #(
  parameter int MAX_ROW_SAMPLES = 4096,
  parameter int MAX_CHANNELS    = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_command,
  input  wire logic [c3ic_pkg::PIX_W-1:0]   in_sample,
  input  wire c3ic_pkg::geo_t               geo,
  input  wire logic [c3ic_pkg::Q_CNT_W-1:0] q_level,
  output logic                              q_push,
  output c3ic_pkg::taps_t                   q_data
);

  localparam int W_LIMIT   = (MAX_ROW_SAMPLES > c3ic_pkg::GEO_MAX) ?
                             c3ic_pkg::GEO_MAX : MAX_ROW_SAMPLES;
  localparam int COL_W     = $clog2(W_LIMIT);
  localparam int WIN_DEPTH = 2 * MAX_CHANNELS;
  localparam int CMP_W     = c3ic_pkg::GEO_W + 1;
  localparam int POS_W     = 2 * c3ic_pkg::GEO_W + 1;
  localparam int PW        = c3ic_pkg::PIX_W;

  // Line stores
  logic [PW-1:0] mem_a [W_LIMIT];
  logic [PW-1:0] mem_b [W_LIMIT];

  // Stream position counters
  logic [COL_W-1:0]              in_col_r, in_col_nxt;
  logic [c3ic_pkg::GEO_W-1:0]    in_row_r, in_row_nxt;
  logic [COL_W-1:0]              out_col_r, out_col_nxt;
  logic [c3ic_pkg::ROW_W-1:0]    out_row_r, out_row_nxt;

  // Written prefix of each line store since reset
  logic [COL_W:0] a_fill_r, b_fill_r;

  // Issue stage signals
  logic              accept, beyond, push, emit, last;
  logic [PW-1:0]     vin;
  logic [POS_W-1:0]  pos, lag;
  logic [CMP_W-1:0]  w_x, h_x, s_x, col_inc, ocol_x, ocol_inc, orow_x, orow_inc;
  logic [2:0]        row_ok_nxt, col_ok_nxt;
  logic              pending;

  // Window stage registers
  logic              f1_v_r, f1_emit_r, f1_last_r;
  logic [COL_W-1:0]  f1_col_r;
  logic [PW-1:0]     f1_val_r;
  logic [2:0]        f1_row_ok_r, f1_col_ok_r;
  logic              a_ok_r, b_ok_r, fwd_r;
  logic [PW-1:0]     fwd_top_r, rd_a_r, rd_b_r;
  logic [PW-1:0]     mid, top;

  logic [WIN_DEPTH-1:0][PW-1:0] win_r [3];
  logic [PW-1:0] newcol   [3];
  logic [PW-1:0] tap_near [3];
  logic [PW-1:0] tap_far  [3];

  // ---------------- issue stage ----------------
  assign pending  = f1_v_r && f1_emit_r;
  assign in_ready = (q_level + c3ic_pkg::Q_CNT_W'(pending)) <
                    c3ic_pkg::Q_CNT_W'(c3ic_pkg::Q_DEPTH);
  assign accept   = in_valid && in_ready;

  assign w_x      = CMP_W'(geo.w);
  assign h_x      = CMP_W'(geo.h);
  assign s_x      = CMP_W'(geo.s);
  assign col_inc  = CMP_W'(in_col_r) + CMP_W'(1);
  assign ocol_x   = CMP_W'(out_col_r);
  assign ocol_inc = ocol_x + CMP_W'(1);
  assign orow_x   = CMP_W'(out_row_r);
  assign orow_inc = orow_x + CMP_W'(1);

  // Past the last row only drains count; inside the frame only samples do
  assign beyond = in_row_r >= geo.h;
  assign push   = beyond ? in_command : !in_command;
  assign vin    = beyond ? '0 : in_sample;

  assign pos  = POS_W'(in_row_r) * POS_W'(geo.w) + POS_W'(in_col_r);
  assign lag  = POS_W'(geo.w) + POS_W'(geo.s);
  assign emit = push && (pos >= lag);
  assign last = (ocol_inc >= w_x) && (orow_inc >= h_x);

  // Taps outside the image read as zero
  assign row_ok_nxt[0] = (out_row_r != '0) && (orow_x <= h_x);
  assign row_ok_nxt[1] = orow_x < h_x;
  assign row_ok_nxt[2] = orow_inc < h_x;
  assign col_ok_nxt[0] = (ocol_x >= s_x) && (ocol_x < w_x + s_x);
  assign col_ok_nxt[1] = ocol_x < w_x;
  assign col_ok_nxt[2] = (ocol_x + s_x) < w_x;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept && push) begin
      if (col_inc >= w_x) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
    end
    if (accept && emit) begin
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (ocol_inc >= w_x) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = ocol_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      a_fill_r  <= '0;
      b_fill_r  <= '0;
      f1_v_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      f1_v_r    <= accept && push;
      if (accept && push && ((COL_W+1)'(in_col_r) == a_fill_r)) begin
        a_fill_r <= a_fill_r + 1'b1;
      end
      if (f1_v_r && ((COL_W+1)'(f1_col_r) == b_fill_r)) begin
        b_fill_r <= b_fill_r + 1'b1;
      end
    end
  end

  // Read both stores and write the new sample at the issue edge
  always_ff @(posedge clk) begin
    if (accept && push) begin
      mem_a[in_col_r] <= vin;
      rd_a_r          <= mem_a[in_col_r];
      rd_b_r          <= mem_b[in_col_r];
      f1_emit_r       <= emit;
      f1_last_r       <= last;
      f1_col_r        <= in_col_r;
      f1_val_r        <= vin;
      f1_row_ok_r     <= row_ok_nxt;
      f1_col_ok_r     <= col_ok_nxt;
      a_ok_r          <= (COL_W+1)'(in_col_r) < a_fill_r;
      b_ok_r          <= (COL_W+1)'(in_col_r) < b_fill_r;
      // Same column written to store B on this edge: take it directly
      fwd_r           <= f1_v_r && (f1_col_r == in_col_r);
      fwd_top_r       <= mid;
    end
    if (f1_v_r) begin
      mem_b[f1_col_r] <= mid;
    end
  end

  // ---------------- window stage ----------------
  assign mid = a_ok_r ? rd_a_r : '0;
  assign top = fwd_r ? fwd_top_r : (b_ok_r ? rd_b_r : '0);

  always_comb begin
    newcol[0] = top;
    newcol[1] = mid;
    newcol[2] = f1_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k] <= '0;
      end
    end else if (f1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k] <= {win_r[k][WIN_DEPTH-2:0], newcol[k]};
      end
    end
  end

  // Taps at one and two strides back, seen after this column shifts in
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tap_near[k] = '0;
      tap_far[k]  = '0;
      for (int j = 1; j <= MAX_CHANNELS; j++) begin
        if (geo.s == c3ic_pkg::STRIDE_W'(j)) begin
          tap_near[k] = win_r[k][j-1];
          tap_far[k]  = win_r[k][2*j-1];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_data.tap[k][0] = (f1_row_ok_r[k] && f1_col_ok_r[0]) ? tap_far[k]  : '0;
      q_data.tap[k][1] = (f1_row_ok_r[k] && f1_col_ok_r[1]) ? tap_near[k] : '0;
      q_data.tap[k][2] = (f1_row_ok_r[k] && f1_col_ok_r[2]) ? newcol[k]   : '0;
    end
    q_data.last = f1_last_r;
  end

  assign q_push = f1_v_r && f1_emit_r;

endmodule

`default_nettype wire

/* rtl/core/c3ic_fifo.sv */
`default_nettype none

module c3ic_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire c3ic_pkg::taps_t               wr_data,
  input  wire logic                          pop,
  output c3ic_pkg::taps_t                    rd_data,
  output logic                               not_empty,
  output logic [c3ic_pkg::Q_CNT_W-1:0]       level
);

  c3ic_pkg::taps_t                entry_r [c3ic_pkg::Q_DEPTH];
  logic [c3ic_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [c3ic_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data   = entry_r[rd_ptr_r];
  assign not_empty = cnt_r != '0;
  assign level     = cnt_r;

endmodule

`default_nettype wire

/* rtl/core/c3ic_back.sv */
`default_nettype none

module c3ic_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire c3ic_pkg::coef_t             coef,
  input  wire logic                        q_valid,
  input  wire c3ic_pkg::taps_t             q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [c3ic_pkg::PIX_W-1:0]       out_sample,
  output logic                             out_frame_end
);

  localparam int PW = c3ic_pkg::PIX_W;

  logic signed [c3ic_pkg::PROD_W-1:0] prod_nxt [3][3];
  logic signed [c3ic_pkg::PROD_W-1:0] prod_r   [3][3];
  logic signed [c3ic_pkg::RSUM_W-1:0] rsum_nxt [3];
  logic signed [c3ic_pkg::RSUM_W-1:0] rsum_r   [3];
  logic signed [c3ic_pkg::SUM_W-1:0]  total;
  logic [PW-1:0]                      clamp_nxt;

  logic s1_v_r, s1_last_r, s2_v_r, s2_last_r, out_v_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3  = !out_v_r || out_ready;
  assign rdy2  = !s2_v_r || rdy3;
  assign rdy1  = !s1_v_r || rdy2;
  assign q_pop = q_valid && rdy1;

  // Signed weight times unsigned sample
  always_comb begin
    logic signed [c3ic_pkg::PROD_W-1:0] wx, sx;
    for (int k = 0; k < 3; k++) begin
      for (int x = 0; x < 3; x++) begin
        wx = c3ic_pkg::PROD_W'($signed(coef.row[k][PW*x +: PW]));
        sx = c3ic_pkg::PROD_W'({1'b0, q_data.tap[k][x]});
        prod_nxt[k][x] = wx * sx;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum_nxt[k] = c3ic_pkg::RSUM_W'(prod_r[k][0]) + c3ic_pkg::RSUM_W'(prod_r[k][1]) +
                    c3ic_pkg::RSUM_W'(prod_r[k][2]);
    end
  end

  always_comb begin
    total = c3ic_pkg::SUM_W'(rsum_r[0]) + c3ic_pkg::SUM_W'(rsum_r[1]) +
            c3ic_pkg::SUM_W'(rsum_r[2]);
    priority if (total[c3ic_pkg::SUM_W-1]) begin
      clamp_nxt = '0;
    end else if (total > c3ic_pkg::SUM_W'(c3ic_pkg::PIX_MAX)) begin
      clamp_nxt = PW'(c3ic_pkg::PIX_MAX);
    end else begin
      clamp_nxt = total[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= q_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r    <= prod_nxt;
      s1_last_r <= q_data.last;
    end
    if (rdy2 && s1_v_r) begin
      rsum_r    <= rsum_nxt;
      s2_last_r <= s1_last_r;
    end
    if (rdy3 && s2_v_r) begin
      out_sample    <= clamp_nxt;
      out_frame_end <= s2_last_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W          = c3ic_pkg::PIX_W;
  localparam int GEO_W          = c3ic_pkg::GEO_W;
  localparam int STRIDE_W       = c3ic_pkg::STRIDE_W;
  localparam int COEF_W         = c3ic_pkg::COEF_W;
  localparam int CFG_IDX_W      = c3ic_pkg::CFG_IDX_W;
  localparam int MAX_IMAGE_ROWS = c3ic_pkg::MAX_IMAGE_ROWS;
  localparam int PIX_MAX        = c3ic_pkg::PIX_MAX;

  localparam int MAX_ROW       = 4096;
  localparam int MAX_CH        = 4;
  localparam int WIN           = 2 * MAX_CH + 1;
  localparam int RANDOM_ITEMS  = 900;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_CAP    = 200;

  typedef enum logic {CMD_SAMPLE = 1'b0, CMD_DRAIN = 1'b1} cmd_e;
  typedef enum {PACE_MIXED, PACE_SWAPPED, PACE_FULL} pace_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [PIX_W-1:0] smp;
  } pixel_txn_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } conv_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = 1'b0;
  logic [PIX_W-1:0]     in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_sample;
  logic                 out_frame_end;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = c3ic_pkg::REG_ROW_SAMPLES;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  conv3x3_interleaved_clamp uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Filter state as the block should hold it
  logic [GEO_W-1:0]    geo_row_samples;
  logic [GEO_W-1:0]    geo_image_rows;
  logic [STRIDE_W-1:0] geo_stride;
  logic [COEF_W-1:0]   kern [3];
  logic [PIX_W-1:0]    ls_recent [MAX_ROW];
  logic [PIX_W-1:0]    ls_older [MAX_ROW];
  logic [PIX_W-1:0]    taps [3][WIN];
  int                  wr_col, wr_row, rd_col, rd_row;
  int                  frames_closed;

  pixel_txn_t   stream_q[$];
  conv_result_t filtered_q[$];
  pixel_txn_t   drv_item;
  pace_e        pace = PACE_MIXED;
  int           mismatches = 0;
  int           useful_items = 0;
  int           hold_asked = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int limit(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic void reset_filter();
    geo_row_samples = c3ic_pkg::RST_ROW_SAMPLES;
    geo_image_rows  = c3ic_pkg::RST_IMAGE_ROWS;
    geo_stride      = c3ic_pkg::RST_CHANNEL_STRIDE;
    kern[0] = c3ic_pkg::RST_COEF_ROW_TOP;
    kern[1] = c3ic_pkg::RST_COEF_ROW_MID;
    kern[2] = c3ic_pkg::RST_COEF_ROW_BOT;
    for (int i = 0; i < MAX_ROW; i++) begin
      ls_recent[i] = '0;
      ls_older[i]  = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int p = 0; p < WIN; p++)
        taps[k][p] = '0;
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
    frames_closed = 0;
  endfunction

  function automatic void shift_in(logic [PIX_W-1:0] v, int w);
    logic [PIX_W-1:0] top, mid;
    top = '0;
    mid = '0;
    if (wr_col < MAX_ROW) begin
      top = ls_older[wr_col];
      mid = ls_recent[wr_col];
      ls_older[wr_col]  = mid;
      ls_recent[wr_col] = v;
    end
    for (int k = 0; k < 3; k++)
      for (int p = WIN - 1; p > 0; p--)
        taps[k][p] = taps[k][p-1];
    taps[0][0] = top;
    taps[1][0] = mid;
    taps[2][0] = v;
    wr_col++;
    if (wr_col >= w) begin
      wr_col = 0;
      wr_row = (wr_row + 1) & 'h1FFF;
    end
  endfunction

  // Advance the filter by one accepted transaction and queue the result it yields
  function automatic void conv_predict(cmd_e cmd, logic [PIX_W-1:0] smp);
    int w, h, s, pos, sum, rr, cc;
    conv_result_t res;
    w = limit(geo_row_samples, MAX_ROW);
    h = limit(geo_image_rows, MAX_IMAGE_ROWS);
    s = limit(geo_stride, MAX_CH);
    pos = wr_row * w + wr_col;
    if (wr_row >= h) begin
      if (cmd == CMD_SAMPLE) return;
      shift_in('0, w);
    end else begin
      if (cmd == CMD_DRAIN) return;
      shift_in(smp, w);
    end
    if (pos < w + s) return;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      rr = rd_row + k - 1;
      if (rr < 0 || rr >= h) continue;
      for (int x = 0; x < 3; x++) begin
        cc = rd_col + (x - 1) * s;
        if (cc < 0 || cc >= w) continue;
        sum += int'(taps[k][(2 - x) * s]) * int'($signed(kern[k][8*x +: 8]));
      end
    end
    if (sum < 0) sum = 0;
    if (sum > PIX_MAX) sum = PIX_MAX;
    res.pix  = PIX_W'(sum);
    res.last = (rd_col + 1 >= w && rd_row + 1 >= h);
    filtered_q.push_back(res);
    if (res.last) begin
      wr_col = 0;
      wr_row = 0;
      rd_col = 0;
      rd_row = 0;
      frames_closed++;
    end else begin
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row = (rd_row + 1) & 'hFFF;
      end
    end
  endfunction

  function automatic void check_result(logic [PIX_W-1:0] pix, logic fend);
    conv_result_t want;
    if (filtered_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: unexpected result: expected none, got out_sample %0d frame_end %0b",
                 $time, pix, fend);
      return;
    end
    want = filtered_q.pop_front();
    if (pix !== want.pix) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: out_sample mismatch: expected %0d, got %0d", $time, want.pix, pix);
    end
    if (fend !== want.last) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: out_frame_end mismatch: expected %0b, got %0b",
                 $time, want.last, fend);
    end
  endfunction

  // Input driver: hold the current transaction until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) conv_predict(cmd_e'(in_command), in_sample);
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 &&
            $urandom_range(0, 99) >= (pace == PACE_MIXED ? 36 :
                                      pace == PACE_SWAPPED ? 46 : 0)) begin
          drv_item = stream_q.pop_front();
          in_valid   <= 1'b1;
          in_command <= drv_item.cmd;
          in_sample  <= drv_item.smp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random back-pressure and long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_sample, out_frame_end);
      if (hold_served != hold_asked) begin
        hold_served <= hold_asked;
        hold_left   <= HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= (pace == PACE_MIXED ? 46 :
                                                pace == PACE_SWAPPED ? 36 : 0));
      end
    end
  end

  task automatic settle();
    do @(negedge clk); while (stream_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      c3ic_pkg::REG_ROW_SAMPLES:    geo_row_samples = data[GEO_W-1:0];
      c3ic_pkg::REG_IMAGE_ROWS:     geo_image_rows  = data[GEO_W-1:0];
      c3ic_pkg::REG_CHANNEL_STRIDE: geo_stride      = data[STRIDE_W-1:0];
      c3ic_pkg::REG_COEF_ROW_TOP:   kern[0] = data;
      c3ic_pkg::REG_COEF_ROW_MID:   kern[1] = data;
      c3ic_pkg::REG_COEF_ROW_BOT:   kern[2] = data;
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup(input logic [GEO_W-1:0] w, input logic [GEO_W-1:0] h,
                       input logic [STRIDE_W-1:0] s, input logic [COEF_W-1:0] top,
                       input logic [COEF_W-1:0] mid, input logic [COEF_W-1:0] bot);
    write_reg(c3ic_pkg::REG_ROW_SAMPLES, COEF_W'(w));
    write_reg(c3ic_pkg::REG_IMAGE_ROWS, COEF_W'(h));
    write_reg(c3ic_pkg::REG_CHANNEL_STRIDE, COEF_W'(s));
    write_reg(c3ic_pkg::REG_COEF_ROW_TOP, top);
    write_reg(c3ic_pkg::REG_COEF_ROW_MID, mid);
    write_reg(c3ic_pkg::REG_COEF_ROW_BOT, bot);
    end_cfg();
  endtask

  function automatic void push_item(cmd_e cmd, logic [PIX_W-1:0] smp);
    pixel_txn_t t;
    t.cmd = cmd;
    t.smp = smp;
    stream_q.push_back(t);
  endfunction

  function automatic logic [PIX_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PIX_W'(PIX_MAX);
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_row();
    logic [COEF_W-1:0] r;
    case ($urandom_range(0, 5))
      0: r = COEF_W'($urandom());
      1: r = {3{8'h7F}};
      2: r = {3{8'h80}};
      default: begin
        for (int b = 0; b < 3; b++) r[8*b +: 8] = 8'($urandom_range(0, 6)) - 8'd3;
      end
    endcase
    return r;
  endfunction

  // One full frame at the current geometry, optionally with dropped stray transactions
  task automatic send_frame(input bit noisy);
    int w, h, s, junk_at, stray_at;
    w = limit(geo_row_samples, MAX_ROW);
    h = limit(geo_image_rows, MAX_IMAGE_ROWS);
    s = limit(geo_stride, MAX_CH);
    junk_at  = $urandom_range(0, w * h - 1);
    stray_at = $urandom_range(0, w + s - 1);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && i == junk_at) push_item(CMD_DRAIN, pick_sample());
      push_item(CMD_SAMPLE, pick_sample());
    end
    for (int i = 0; i < w + s; i++) begin
      if (noisy && i == stray_at) push_item(CMD_SAMPLE, pick_sample());
      push_item(CMD_DRAIN, pick_sample());
    end
    useful_items += w * h + w + s;
  endtask

  task automatic random_setup();
    logic [GEO_W-1:0]    w, h;
    logic [STRIDE_W-1:0] s;
    w = ($urandom_range(0, 15) == 0) ? '0 : GEO_W'($urandom_range(1, 12));
    h = ($urandom_range(0, 15) == 0) ? '0 : GEO_W'($urandom_range(1, 5));
    s = ($urandom_range(0, 3) == 0) ? STRIDE_W'($urandom_range(0, 7))
                                     : STRIDE_W'($urandom_range(1, 4));
    if ($urandom_range(0, 3) == 0)
      setup(w, h, s, c3ic_pkg::RST_COEF_ROW_TOP, c3ic_pkg::RST_COEF_ROW_MID,
            c3ic_pkg::RST_COEF_ROW_BOT);
    else
      setup(w, h, s, pick_row(), pick_row(), pick_row());
  endtask

  initial begin
    int start_frames;
    reset_filter();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Small frame, with a drain too early and a sample too late; both are dropped
    setup(13'd3, 13'd3, 3'd1, c3ic_pkg::RST_COEF_ROW_TOP, c3ic_pkg::RST_COEF_ROW_MID,
          c3ic_pkg::RST_COEF_ROW_BOT);
    push_item(CMD_DRAIN, 8'h5A);
    push_item(CMD_SAMPLE, 8'd0);
    push_item(CMD_SAMPLE, 8'd255);
    push_item(CMD_SAMPLE, 8'd255);
    push_item(CMD_SAMPLE, 8'd0);
    push_item(CMD_SAMPLE, 8'd255);
    push_item(CMD_SAMPLE, 8'd0);
    push_item(CMD_SAMPLE, 8'd1);
    push_item(CMD_SAMPLE, 8'd128);
    push_item(CMD_SAMPLE, 8'd254);
    push_item(CMD_SAMPLE, 8'hFF);
    repeat (4) push_item(CMD_DRAIN, 8'hA5);
    settle();

    // Zero geometry acts as a single sample, single row, stride one
    setup(13'd0, 13'd0, 3'd0, 24'h000000, 24'h000100, 24'h000000);
    push_item(CMD_SAMPLE, 8'hC3);
    repeat (2) push_item(CMD_DRAIN, 8'h3C);
    settle();

    // Stride above the channel limit, extreme weights
    setup(13'd2, 13'd1, 3'd7, {3{8'h7F}}, 24'h807F80, {3{8'h80}});
    push_item(CMD_SAMPLE, 8'd255);
    push_item(CMD_SAMPLE, 8'd77);
    repeat (6) push_item(CMD_DRAIN, 8'd0);
    settle();

    // Shrink the row length in the middle of a frame, then finish it step by step
    setup(13'd6, 13'd3, 3'd2, pick_row(), pick_row(), pick_row());
    repeat (10) push_item(CMD_SAMPLE, pick_sample());
    settle();
    write_reg(c3ic_pkg::REG_ROW_SAMPLES, 24'd4);
    end_cfg();
    start_frames = frames_closed;
    while (frames_closed == start_frames) begin
      push_item((wr_row >= limit(geo_image_rows, MAX_IMAGE_ROWS)) ? CMD_DRAIN : CMD_SAMPLE,
                pick_sample());
      do @(negedge clk); while (stream_q.size() != 0 || in_valid);
    end

    for (int p = 0; p < 3; p++) begin
      settle();
      pace = pace_e'(p);
      // Stall the output long enough for the input to back up
      setup(13'd12, 13'd4, 3'd3, pick_row(), pick_row(), pick_row());
      send_frame(1'b0);
      hold_asked++;
      while (useful_items < RANDOM_ITEMS * (p + 1) / 3) begin
        if ($urandom_range(0, 2) != 0) begin
          settle();
          random_setup();
        end
        send_frame($urandom_range(0, 9) == 0);
      end
    end
    settle();

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/c3ic_pkg.sv
rtl/core/c3ic_front.sv
rtl/core/c3ic_fifo.sv
rtl/core/c3ic_back.sv
rtl/core/conv3x3_interleaved_clamp.sv
tb/tb_top.sv
